// ----- design/udpck_pkg.sv -----
package udpck_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_UDP = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Byte offsets within an IPv4 packet with a 20-byte header
  localparam logic [POS_W-1:0] POS_PROTO    = 17'd9;
  localparam logic [POS_W-1:0] POS_SRC_ADDR = 17'd12;
  localparam logic [POS_W-1:0] POS_ULEN_LO  = 17'd25;
  localparam logic [POS_W-1:0] POS_CSUM_HI  = 17'd26;
  localparam logic [POS_W-1:0] POS_CSUM_LO  = 17'd27;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 17'd28;
  localparam logic [POS_W-1:0] IP_HDR_LEN   = 17'd20;

  localparam logic [7:0]  UDP_PROTO   = 8'd17;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [15:0] SUM_ALL_ONE = 16'hffff;

  // One's-complement 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- design/udp_checksum_engine.sv -----
// Channel  | Ports                                        | Direction
// input    | in_valid, in_stall, in_data_byte, in_last    | one packet byte per item
// result   | out_valid, out_stall, out_checksum,          | one item per packet,
//          | out_checksum_ok, out_status                  | after its last byte
//
// One byte is taken every cycle while in_stall is low; the one's-complement add on
// the running sum sets that rate. A result passes through the final stage to the
// output register after the last byte of its packet is accepted.
// Reset (synchronous, rst_n low) empties every stage and clears the sums.
// A stalled result holds the output register; an item behind it waits in the
// final stage, and the input side stalls only when a last byte cannot move on.
module udp_checksum_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic        out_checksum_ok,
  output logic [1:0]  out_status
);
  import udpck_pkg::*;

  // Input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  // Per-packet state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [15:0]      ulen_r, ulen_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [15:0]      recv_r, recv_nxt;

  // Final stage: snapshot of the state after a last byte
  logic             fin_valid_r;
  logic [POS_W-1:0] fin_pos_r;
  logic [15:0]      fin_sum_r;
  logic [7:0]       fin_held_r;
  logic [15:0]      fin_ulen_r;
  logic [7:0]       fin_proto_r;
  logic [15:0]      fin_recv_r;

  // Output register
  logic             out_valid_r;
  logic [15:0]      out_csum_r;
  logic             out_ok_r;
  status_t          out_status_r;

  // Flow control
  logic out_free, fin_free, fin_adv, s1_adv, s1_free, in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign fin_adv   = fin_valid_r && out_free;
  assign fin_free  = !fin_valid_r || out_free;
  assign s1_adv    = s1_valid_r && (!s1_last_r || fin_free);
  assign s1_free   = !s1_valid_r || s1_adv;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

  // Per-byte state update
  logic        in_word_span;
  logic        in_payload;
  logic [15:0] word;
  logic [15:0] sum_w1;

  assign in_payload   = (pos_r >= POS_PAYLOAD) && (pos_r < (IP_HDR_LEN + {1'b0, ulen_r}));
  assign in_word_span = ((pos_r >= POS_SRC_ADDR) && (pos_r <= POS_ULEN_LO)) || in_payload;
  assign word         = {held_r, s1_byte_r};
  assign sum_w1       = ones_add(sum_r, word);

  always_comb begin
    pos_nxt   = (pos_r != POS_MAX) ? pos_r + 17'd1 : pos_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    ulen_nxt  = ulen_r;
    proto_nxt = proto_r;
    recv_nxt  = recv_r;
    if (pos_r == POS_PROTO) begin
      proto_nxt = s1_byte_r;
      sum_nxt   = ones_add(sum_r, {8'd0, s1_byte_r});
    end
    if (in_word_span) begin
      if (!pos_r[0]) begin
        held_nxt = s1_byte_r;
      end else if (pos_r == POS_ULEN_LO) begin
        // UDP length counts twice: header word and pseudo-header copy
        ulen_nxt = word;
        sum_nxt  = ones_add(sum_w1, word);
      end else begin
        sum_nxt = sum_w1;
      end
    end
    if (pos_r == POS_CSUM_HI) recv_nxt = {s1_byte_r, 8'd0};
    if (pos_r == POS_CSUM_LO) recv_nxt = {recv_r[15:8], s1_byte_r};
  end

  // State registers; cleared after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      held_r  <= '0;
      ulen_r  <= '0;
      proto_r <= '0;
      recv_r  <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        pos_r   <= '0;
        sum_r   <= '0;
        held_r  <= '0;
        ulen_r  <= '0;
        proto_r <= '0;
        recv_r  <= '0;
      end else begin
        pos_r   <= pos_nxt;
        sum_r   <= sum_nxt;
        held_r  <= held_nxt;
        ulen_r  <= ulen_nxt;
        proto_r <= proto_nxt;
        recv_r  <= recv_nxt;
      end
    end
  end

  // Final stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= (s1_adv && s1_last_r) || (fin_valid_r && !out_free);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      fin_pos_r   <= pos_r;
      fin_sum_r   <= sum_nxt;
      fin_held_r  <= held_nxt;
      fin_ulen_r  <= ulen_nxt;
      fin_proto_r <= proto_nxt;
      fin_recv_r  <= recv_nxt;
    end
  end

  // Result: odd-length pad, complement, verify and status
  logic [15:0] sum_pad, csum_raw, csum_calc, sum_chk;
  logic        short_pkt;
  status_t     status_calc;

  assign sum_pad   = fin_ulen_r[0] ? ones_add(fin_sum_r, {fin_held_r, 8'd0}) : fin_sum_r;
  assign csum_raw  = ~sum_pad;
  assign csum_calc = (csum_raw == 16'd0) ? SUM_ALL_ONE : csum_raw;
  assign sum_chk   = ones_add(sum_pad, fin_recv_r);
  assign short_pkt = ({1'b0, fin_pos_r} + 18'd1) < ({1'b0, IP_HDR_LEN} + {2'd0, fin_ulen_r});

  always_comb begin
    priority if (fin_pos_r < POS_ULEN_LO) status_calc = ST_SHORT;
    else if (fin_proto_r != UDP_PROTO)    status_calc = ST_NOT_UDP;
    else if (fin_ulen_r < UDP_HDR_LEN)    status_calc = ST_BAD_LEN;
    else if (short_pkt)                   status_calc = ST_SHORT;
    else                                  status_calc = ST_OK;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      out_status_r <= status_calc;
      out_csum_r   <= (status_calc == ST_OK) ? csum_calc : 16'd0;
      out_ok_r     <= (status_calc == ST_OK) && (sum_chk == SUM_ALL_ONE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_checksum    = out_csum_r;
  assign out_checksum_ok = out_ok_r;
  assign out_status      = out_status_r;

endmodule

// ----- design/udpck_checker.sv -----
module udpck_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_checksum,
  input logic        out_checksum_ok,
  input logic [1:0]  out_status
);
  import udpck_pkg::*;

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_last))
    else $error("input item changed while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum)
      && $stable(out_checksum_ok) && $stable(out_status))
    else $error("result changed while stalled");

  // Error items carry a zero checksum and no verify flag
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_checksum == 16'd0) && !out_checksum_ok)
    else $error("error item with nonzero checksum fields");

  // A good item never carries a zero checksum
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> (out_checksum != 16'd0))
    else $error("good item with zero checksum");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind udp_checksum_engine udpck_checker u_udpck_checker (.*);

// ----- tb/tb_udp_checksum_engine.sv -----
module tb_udp_checksum_engine;
  import udpck_pkg::*;

  localparam int unsigned LIMIT    = 1000000;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned TAIL     = 12;

  typedef enum {PAT_RAND, PAT_ZERO, PAT_ONES} pat_t;
  typedef enum {FIX_NONE, FIX_FIELD, FIX_ZERO_SUM} fix_t;
  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [15:0] csum;
    logic        ok;
    status_t     st;
  } ck_res_t;

  // running state of one packet, plus the result produced on its last byte
  typedef struct {
    logic [16:0] pos;
    logic [15:0] sum;
    logic [7:0]  hi;
    logic [15:0] ulen;
    logic [7:0]  proto;
    logic [15:0] rxf;
    bit          done;
    ck_res_t     res;
  } ck_state_t;

  typedef struct {
    int unsigned len;
    logic [7:0]  proto;
    logic [15:0] ulen;
    pat_t        pat;
    fix_t        fx;
    bit          lit;
    status_t     lit_st;
  } pkt_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_checksum;
  logic        out_checksum_ok;
  logic [1:0]  out_status;

  ck_state_t   ck_state;
  ck_res_t     pending_sums [$];
  logic [7:0]  pkt_bytes [$];
  bit          lit_on;
  ck_res_t     lit_res;
  bit          gappy;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned n_bytes;
  int unsigned n_results;
  int unsigned n_good_pkts;
  int unsigned n_fail;
  int unsigned cyc;

  // directed packets; error rows carry their result, the rest use the predictor
  pkt_row_t dir_rows [16] = '{
    '{1,      8'd17,  16'd8,     PAT_RAND, FIX_NONE,     1'b1, ST_SHORT},
    '{25,     8'd17,  16'd8,     PAT_RAND, FIX_NONE,     1'b1, ST_SHORT},
    '{26,     8'd17,  16'd8,     PAT_RAND, FIX_NONE,     1'b1, ST_SHORT},
    '{28,     8'd6,   16'd8,     PAT_RAND, FIX_NONE,     1'b1, ST_NOT_UDP},
    '{28,     8'hff,  16'd8,     PAT_ONES, FIX_NONE,     1'b1, ST_NOT_UDP},
    '{28,     8'd0,   16'd8,     PAT_ZERO, FIX_NONE,     1'b1, ST_NOT_UDP},
    '{28,     8'd17,  16'd7,     PAT_RAND, FIX_NONE,     1'b1, ST_BAD_LEN},
    '{28,     8'd17,  16'd0,     PAT_ZERO, FIX_NONE,     1'b1, ST_BAD_LEN},
    '{30,     8'd17,  16'hffff,  PAT_RAND, FIX_NONE,     1'b1, ST_SHORT},
    '{28,     8'd17,  16'd8,     PAT_RAND, FIX_NONE,     1'b0, ST_OK},
    '{28,     8'd17,  16'd8,     PAT_ZERO, FIX_FIELD,    1'b0, ST_OK},
    '{29,     8'd17,  16'd9,     PAT_RAND, FIX_FIELD,    1'b0, ST_OK},
    '{40,     8'd17,  16'd20,    PAT_ONES, FIX_NONE,     1'b0, ST_OK},
    '{50,     8'd17,  16'd15,    PAT_RAND, FIX_FIELD,    1'b0, ST_OK},
    '{30,     8'd17,  16'd10,    PAT_ZERO, FIX_ZERO_SUM, 1'b0, ST_OK},
    // odd pad with trailing bytes after the UDP length
    '{45,     8'd17,  16'd21,    PAT_RAND, FIX_FIELD,    1'b0, ST_OK}
  };

  udp_checksum_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum    (out_checksum),
    .out_checksum_ok (out_checksum_ok),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one's-complement add, end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] t;
    t = 32'(a) + 32'(b);
    return t[15:0] + t[31:16];
  endfunction

  function automatic ck_state_t ck_clear();
    ck_state_t s;
    s.pos   = '0;
    s.sum   = '0;
    s.hi    = '0;
    s.ulen  = '0;
    s.proto = '0;
    s.rxf   = '0;
    s.done  = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  // advance the checksum state by one byte; sets done and res on the last byte
  function automatic ck_state_t sum_byte(input ck_state_t s, input logic [7:0] b,
                                         input logic is_end);
    int unsigned pi;
    int unsigned lim;
    int unsigned total;
    logic [15:0] w;
    logic [15:0] sm;
    status_t     st;
    ck_res_t     r;
    pi     = s.pos;
    lim    = IP_HDR_LEN + s.ulen;
    s.done = 1'b0;
    if (s.pos == POS_PROTO) begin
      s.proto = b;
      s.sum   = oc_add(s.sum, {8'h00, b});
    end
    if ((s.pos >= POS_SRC_ADDR && s.pos <= POS_ULEN_LO) ||
        (s.pos >= POS_PAYLOAD && pi < lim)) begin
      if (!s.pos[0]) begin
        s.hi = b;
      end else begin
        w     = {s.hi, b};
        s.sum = oc_add(s.sum, w);
        // UDP length counts once in the header and once in the pseudo-header
        if (s.pos == POS_ULEN_LO) begin
          s.ulen = w;
          s.sum  = oc_add(s.sum, w);
        end
      end
    end
    if (s.pos == POS_CSUM_HI) s.rxf = {b, 8'h00};
    if (s.pos == POS_CSUM_LO) s.rxf[7:0] = b;
    if (s.pos != POS_MAX) s.pos = s.pos + 1'b1;
    if (is_end) begin
      total = pi + 1;
      if (total < 26) st = ST_SHORT;
      else if (s.proto != UDP_PROTO) st = ST_NOT_UDP;
      else if (s.ulen < UDP_HDR_LEN) st = ST_BAD_LEN;
      else if (total < IP_HDR_LEN + s.ulen) st = ST_SHORT;
      else st = ST_OK;
      r = '0;
      r.st = st;
      if (st == ST_OK) begin
        sm = s.sum;
        if (s.ulen[0]) sm = oc_add(sm, {s.hi, 8'h00});
        r.csum = ~sm;
        if (r.csum == 16'h0000) r.csum = SUM_ALL_ONE;
        r.ok = (oc_add(sm, s.rxf) == SUM_ALL_ONE);
      end
      s      = ck_clear();
      s.res  = r;
      s.done = 1'b1;
    end
    return s;
  endfunction

  // result of the packet now in pkt_bytes, from a fresh state
  function automatic ck_res_t dry_run();
    ck_state_t s;
    s = ck_clear();
    foreach (pkt_bytes[i]) s = sum_byte(s, pkt_bytes[i], i == pkt_bytes.size() - 1);
    return s.res;
  endfunction

  function automatic void build_pkt(input int unsigned n, input logic [7:0] proto,
                                    input logic [15:0] ulen, input pat_t pat,
                                    input fix_t fx);
    ck_res_t r;
    logic [7:0] b;
    pkt_bytes.delete();
    for (int unsigned i = 0; i < n; i++) begin
      case (pat)
        PAT_ZERO: b = 8'h00;
        PAT_ONES: b = 8'hff;
        default:  b = 8'($urandom);
      endcase
      if (i == 9) b = proto;
      else if (i == 24) b = ulen[15:8];
      else if (i == 25) b = ulen[7:0];
      pkt_bytes.push_back(b);
    end
    // first payload word chosen so that the sum folds to all ones
    if (fx == FIX_ZERO_SUM) begin
      pkt_bytes[28] = 8'h00;
      pkt_bytes[29] = 8'h00;
      r = dry_run();
      pkt_bytes[28] = r.csum[15:8];
      pkt_bytes[29] = r.csum[7:0];
    end
    // received field set to the correct checksum
    if (fx == FIX_FIELD) begin
      r = dry_run();
      pkt_bytes[26] = r.csum[15:8];
      pkt_bytes[27] = r.csum[7:0];
    end
  endfunction

  // offer one byte, wait for acceptance, update the prediction
  task automatic send_byte(input logic [7:0] b, input logic is_end);
    ck_res_t r;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= is_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    ck_state = sum_byte(ck_state, b, is_end);
    if (ck_state.done) begin
      r = lit_on ? lit_res : ck_state.res;
      pending_sums.push_back(r);
    end
    // bursts with random gaps
    if (gappy && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  task automatic send_pkt(input bit lit, input status_t lst);
    lit_on       = lit;
    lit_res      = '0;
    lit_res.st   = lst;
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    lit_on = 1'b0;
  endtask

  // main stimulus
  initial begin
    int unsigned n;
    int unsigned kind;
    int unsigned rnd_bytes;
    int unsigned rnd_pkts;
    logic [7:0]  proto;
    logic [15:0] ulen;
    fix_t        fx;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last      <= 1'b0;
    rst_n        <= 1'b0;
    gappy        = 1'b1;
    burst_left   = 0;
    hold_req     = 1'b0;
    lit_on       = 1'b0;
    lit_res      = '0;
    ck_state     = ck_clear();
    rnd_bytes    = 0;
    rnd_pkts     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      gappy = (dir_rows[i].len < 1000);
      build_pkt(dir_rows[i].len, dir_rows[i].proto, dir_rows[i].ulen,
                dir_rows[i].pat, dir_rows[i].fx);
      send_pkt(dir_rows[i].lit, dir_rows[i].lit_st);
    end

    // long receiver hold-off while packets keep coming
    gappy    = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 14; k++) begin
      if (k < 12) begin
        build_pkt(1, UDP_PROTO, 16'd8, PAT_RAND, FIX_NONE);
        send_pkt(1'b1, ST_SHORT);
      end else begin
        build_pkt(28, UDP_PROTO, 16'd8, PAT_RAND, FIX_FIELD);
        send_pkt(1'b0, ST_OK);
      end
    end

    // random packets, mostly well formed
    while (n_bytes < 550 || rnd_pkts < 2) begin
      kind  = $urandom_range(0, 99);
      proto = UDP_PROTO;
      fx    = FIX_NONE;
      ulen  = 16'($urandom_range(8, 24));
      n     = 20 + ulen;
      if (kind < 70) begin
        if ($urandom_range(0, 9) == 0) n = n + $urandom_range(1, 6);
        if ($urandom_range(0, 1) != 0) fx = FIX_FIELD;
      end else if (kind < 78) begin
        n = $urandom_range(1, 27);
      end else if (kind < 86) begin
        proto = 8'($urandom_range(0, 255));
        if (proto == UDP_PROTO) proto = proto + 8'd1;
      end else if (kind < 93) begin
        ulen = 16'($urandom_range(0, 7));
        n    = $urandom_range(26, 40);
      end else begin
        ulen = 16'($urandom_range(64, 65535));
        n    = $urandom_range(26, 60);
      end
      gappy = ($urandom_range(0, 4) != 0);
      build_pkt(n, proto, ulen, PAT_RAND, fx);
      send_pkt(1'b0, ST_OK);
      rnd_bytes += n;
      rnd_pkts++;
    end

    // drain
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("Sent %0d packet bytes, %0d of them in %0d random packets.",
             n_bytes, rnd_bytes, rnd_pkts);
    $display("Checked %0d results, %0d with ok status; %0d mismatches.",
             n_results, n_good_pkts, n_fail);
    if (n_fail == 0) begin
      $display("udp_checksum_engine test passed");
    end else begin
      $display("udp_checksum_engine test failed");
    end
    $finish;
  end

  // result side stall: changing patterns, plus one long hold-off on request
  initial begin
    int unsigned left_in_mode;
    rx_mode_t    mode;
    out_stall    <= 1'b0;
    left_in_mode = 0;
    mode         = RX_FREE;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (left_in_mode == 0) begin
          mode         = rx_mode_t'($urandom_range(0, 3));
          left_in_mode = $urandom_range(20, 120);
        end
        left_in_mode--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ((left_in_mode % 7) < 3);
        endcase
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    ck_res_t e;
    bit      bad;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_sums.size() == 0) begin
        $error("result with no packet pending: checksum %h ok %b status %0d",
               out_checksum, out_checksum_ok, out_status);
        n_fail++;
      end else begin
        e   = pending_sums.pop_front();
        bad = 1'b0;
        if (e.st == ST_OK) n_good_pkts++;
        if (out_checksum !== e.csum) begin
          $error("checksum: expected %h, actual %h", e.csum, out_checksum);
          bad = 1'b1;
        end
        if (out_checksum_ok !== e.ok) begin
          $error("checksum_ok: expected %b, actual %b", e.ok, out_checksum_ok);
          bad = 1'b1;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, out_status);
          bad = 1'b1;
        end
        if (bad) n_fail++;
      end
    end
  end

  // counters, and timeout
  initial begin
    cyc         = 0;
    n_bytes     = 0;
    n_results   = 0;
    n_good_pkts = 0;
    n_fail      = 0;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("udp_checksum_engine test failed");
      $finish;
    end
  end

endmodule
